// ===== rtl/core/lc3_pkg.sv =====
// Shared types and constants for the LC-3 instruction core.
`timescale 1ns / 1ps
package lc3_pkg;

  // Input modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_SETPC = 2'd2;
  localparam logic [1:0] MODE_EXEC  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RTI   = 3'd1;
  localparam logic [2:0] ST_RES   = 3'd2;
  localparam logic [2:0] ST_LIMIT = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;

  // Opcodes
  localparam logic [3:0] OPC_BR   = 4'd0;
  localparam logic [3:0] OPC_ADD  = 4'd1;
  localparam logic [3:0] OPC_LD   = 4'd2;
  localparam logic [3:0] OPC_ST   = 4'd3;
  localparam logic [3:0] OPC_JSR  = 4'd4;
  localparam logic [3:0] OPC_AND  = 4'd5;
  localparam logic [3:0] OPC_LDR  = 4'd6;
  localparam logic [3:0] OPC_STR  = 4'd7;
  localparam logic [3:0] OPC_RTI  = 4'd8;
  localparam logic [3:0] OPC_NOT  = 4'd9;
  localparam logic [3:0] OPC_LDI  = 4'd10;
  localparam logic [3:0] OPC_STI  = 4'd11;
  localparam logic [3:0] OPC_JMP  = 4'd12;
  localparam logic [3:0] OPC_RES  = 4'd13;
  localparam logic [3:0] OPC_LEA  = 4'd14;
  localparam logic [3:0] OPC_TRAP = 4'd15;

  // Trap vectors
  localparam logic [7:0] TV_GETC  = 8'h20;
  localparam logic [7:0] TV_OUT   = 8'h21;
  localparam logic [7:0] TV_PUTS  = 8'h22;
  localparam logic [7:0] TV_IN    = 8'h23;
  localparam logic [7:0] TV_PUTSP = 8'h24;
  localparam logic [7:0] TV_HALT  = 8'h25;

  localparam logic [2:0] CC_N = 3'd4;
  localparam logic [2:0] CC_Z = 3'd2;
  localparam logic [2:0] CC_P = 3'd1;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_WRITE, OP_READ, OP_SETPC, OP_FETCH, OP_DECODE,
    OP_EXEC, OP_IND, OP_LOADWB, OP_STI, OP_SRD, OP_SCHK, OP_SHI, OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic       halted;
    logic [3:0] opcode;
    logic [7:0] vector;
    logic       word_zero;
    logic       hi_zero;
    logic       str_full;
  } dp_stat_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v == 16'd0) return CC_Z;
    else if (v[15]) return CC_N;
    else return CC_P;
  endfunction

endpackage

// ===== rtl/core/lc3_dp.sv =====
// Datapath: memory, register file, PC, flags, step counter and result registers.
`timescale 1ns / 1ps
module lc3_dp import lc3_pkg::*; #(
  parameter int ADDR_BITS        = 16,
  parameter int MAX_STRING_CHARS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_address,
  input  logic [15:0] in_data,
  input  logic [7:0]  in_char_in,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output dp_stat_t    stat,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_char_out,
  output logic [15:0] out_read_data,
  output logic [15:0] out_pc_now,
  output logic [2:0]  out_cond_code,
  output logic        out_halted,
  output logic [2:0]  out_status,
  output logic        out_last
);

  localparam int MEM_DEPTH = 1 << ADDR_BITS;
  localparam int CNT_W     = $clog2(MAX_STRING_CHARS + 1);

  logic [15:0] mem [MEM_DEPTH];
  logic [15:0] mem_q;
  logic [ADDR_BITS-1:0] mem_addr;
  logic        mem_we, mem_re;
  logic [15:0] mem_wd;

  logic [15:0] addr_r, data_r, ir_r, pc_r, ra_r, rb_r, str_addr_r;
  logic [7:0]  ch_r, pend_r, w_r;
  logic [2:0]  cc_r, status_r;
  logic        halt_r, have_pend_r;
  logic [31:0] steps_r, limit_r;
  logic [1:0]  kind_r;
  logic [CNT_W-1:0] n_r;
  logic [15:0] rf_r [8];

  logic        out_valid_r, out_last_r, out_halted_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_char_r;
  logic [15:0] out_rdata_r, out_pc_r;
  logic [2:0]  out_cc_r, out_status_r;

  logic [3:0]  opc;
  logic [2:0]  dr;
  logic [15:0] off9, off11, off6, imm5, pc_off9, base_off6, alu_b, alu_v;
  logic [31:0] steps_inc;
  logic        limit_hit, full;
  logic [2:0]  trunc_status;

  assign opc       = ir_r[15:12];
  assign dr        = ir_r[11:9];
  assign off9      = {{7{ir_r[8]}}, ir_r[8:0]};
  assign off11     = {{5{ir_r[10]}}, ir_r[10:0]};
  assign off6      = {{10{ir_r[5]}}, ir_r[5:0]};
  assign imm5      = {{11{ir_r[4]}}, ir_r[4:0]};
  assign pc_off9   = pc_r + off9;
  assign base_off6 = ra_r + off6;
  assign alu_b     = ir_r[5] ? imm5 : rb_r;
  assign alu_v     = (opc == OPC_ADD) ? ra_r + alu_b : ra_r & alu_b;
  assign steps_inc = (steps_r == 32'hFFFF_FFFF) ? steps_r : steps_r + 32'd1;
  assign limit_hit = (limit_r != 32'd0) && (steps_inc >= limit_r);
  assign full      = n_r >= CNT_W'(MAX_STRING_CHARS);
  assign trunc_status = (status_r == ST_LIMIT) ? ST_LIMIT : ST_TRUNC;

  always_comb begin
    stat.halted    = halt_r;
    stat.opcode    = opc;
    stat.vector    = ir_r[7:0];
    stat.word_zero = mem_q == 16'd0;
    stat.hi_zero   = w_r == 8'd0;
    stat.str_full  = full;
  end

  // Single memory port
  always_comb begin
    mem_addr = addr_r[ADDR_BITS-1:0];
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wd   = rb_r;
    case (cmd.op)
      OP_WRITE: begin
        mem_we = 1'b1;
        mem_wd = data_r;
      end
      OP_READ: mem_re = 1'b1;
      OP_FETCH: begin
        mem_addr = pc_r[ADDR_BITS-1:0];
        mem_re   = 1'b1;
      end
      OP_EXEC: begin
        case (opc)
          OPC_LD, OPC_LDI, OPC_STI: begin
            mem_addr = pc_off9[ADDR_BITS-1:0];
            mem_re   = 1'b1;
          end
          OPC_LDR: begin
            mem_addr = base_off6[ADDR_BITS-1:0];
            mem_re   = 1'b1;
          end
          OPC_ST: begin
            mem_addr = pc_off9[ADDR_BITS-1:0];
            mem_we   = 1'b1;
          end
          OPC_STR: begin
            mem_addr = base_off6[ADDR_BITS-1:0];
            mem_we   = 1'b1;
          end
          default: ;
        endcase
      end
      OP_IND: begin
        mem_addr = mem_q[ADDR_BITS-1:0];
        mem_re   = 1'b1;
      end
      OP_STI: begin
        mem_addr = mem_q[ADDR_BITS-1:0];
        mem_we   = 1'b1;
      end
      OP_SRD: begin
        mem_addr = str_addr_r[ADDR_BITS-1:0];
        mem_re   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= 16'd0;
      cc_r        <= CC_Z;
      halt_r      <= 1'b0;
      steps_r     <= 32'd0;
      limit_r     <= 32'd0;
      have_pend_r <= 1'b0;
      status_r    <= ST_OK;
      kind_r      <= KIND_DONE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) rf_r[i] <= 16'd0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      case (cmd.op)
        OP_LOAD: begin
          addr_r      <= in_address;
          data_r      <= in_data;
          ch_r        <= in_char_in;
          kind_r      <= (in_mode == MODE_READ) ? KIND_READ : KIND_DONE;
          status_r    <= ST_OK;
          have_pend_r <= 1'b0;
          n_r         <= '0;
        end
        OP_SETPC: begin
          pc_r    <= data_r;
          halt_r  <= 1'b0;
          steps_r <= 32'd0;
        end
        OP_DECODE: begin
          ir_r <= mem_q;
          pc_r <= pc_r + 16'd1;
          ra_r <= rf_r[(mem_q[15:12] == OPC_TRAP) ? 3'd0 : mem_q[8:6]];
          rb_r <= rf_r[(mem_q[15:12] == OPC_ADD || mem_q[15:12] == OPC_AND) ?
                       mem_q[2:0] : mem_q[11:9]];
        end
        OP_EXEC: begin
          if (opc != OPC_RTI && opc != OPC_RES) begin
            steps_r <= steps_inc;
            if (limit_hit) begin
              halt_r   <= 1'b1;
              status_r <= ST_LIMIT;
            end
          end
          case (opc)
            OPC_BR: if ((dr & cc_r) != 3'd0) pc_r <= pc_off9;
            OPC_ADD, OPC_AND: begin
              rf_r[dr] <= alu_v;
              cc_r     <= cc_of(alu_v);
            end
            OPC_JSR: begin
              rf_r[7] <= pc_r;
              pc_r    <= ir_r[11] ? pc_r + off11 : ra_r;
            end
            OPC_RTI: begin
              halt_r   <= 1'b1;
              status_r <= ST_RTI;
            end
            OPC_RES: begin
              halt_r   <= 1'b1;
              status_r <= ST_RES;
            end
            OPC_NOT: begin
              rf_r[dr] <= ~ra_r;
              cc_r     <= cc_of(~ra_r);
            end
            OPC_JMP: pc_r <= ra_r;
            OPC_LEA: rf_r[dr] <= pc_off9;
            OPC_TRAP: begin
              case (ir_r[7:0])
                TV_GETC: rf_r[0] <= {8'd0, ch_r};
                TV_OUT: begin
                  pend_r      <= ra_r[7:0];
                  have_pend_r <= 1'b1;
                end
                TV_IN: begin
                  rf_r[0]     <= {8'd0, ch_r};
                  pend_r      <= ch_r;
                  have_pend_r <= 1'b1;
                end
                TV_PUTS, TV_PUTSP: str_addr_r <= ra_r;
                TV_HALT: halt_r <= 1'b1;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        OP_LOADWB: begin
          rf_r[dr] <= mem_q;
          cc_r     <= cc_of(mem_q);
        end
        OP_SRD: str_addr_r <= str_addr_r + 16'd1;
        OP_SCHK: begin
          w_r <= mem_q[15:8];
          if (mem_q != 16'd0) begin
            if (full) begin
              status_r <= trunc_status;
            end else begin
              // hand the held character on now that another follows
              if (have_pend_r) begin
                out_valid_r  <= 1'b1;
                out_kind_r   <= KIND_CHAR;
                out_char_r   <= pend_r;
                out_rdata_r  <= 16'd0;
                out_pc_r     <= pc_r;
                out_cc_r     <= cc_r;
                out_halted_r <= halt_r;
                out_status_r <= ST_OK;
                out_last_r   <= 1'b0;
              end
              pend_r      <= mem_q[7:0];
              have_pend_r <= 1'b1;
              n_r         <= n_r + CNT_W'(1);
            end
          end
        end
        OP_SHI: begin
          if (w_r != 8'd0) begin
            if (full) begin
              status_r <= trunc_status;
            end else begin
              if (have_pend_r) begin
                out_valid_r  <= 1'b1;
                out_kind_r   <= KIND_CHAR;
                out_char_r   <= pend_r;
                out_rdata_r  <= 16'd0;
                out_pc_r     <= pc_r;
                out_cc_r     <= cc_r;
                out_halted_r <= halt_r;
                out_status_r <= ST_OK;
                out_last_r   <= 1'b0;
              end
              pend_r      <= w_r;
              have_pend_r <= 1'b1;
              n_r         <= n_r + CNT_W'(1);
            end
          end
        end
        OP_DONE: begin
          out_valid_r  <= 1'b1;
          out_kind_r   <= have_pend_r ? KIND_CHAR : kind_r;
          out_char_r   <= have_pend_r ? pend_r : 8'd0;
          out_rdata_r  <= (kind_r == KIND_READ) ? mem_q : 16'd0;
          out_pc_r     <= pc_r;
          out_cc_r     <= cc_r;
          out_halted_r <= halt_r;
          out_status_r <= status_r;
          out_last_r   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_char_out  = out_char_r;
  assign out_read_data = out_rdata_r;
  assign out_pc_now    = out_pc_r;
  assign out_cond_code = out_cc_r;
  assign out_halted    = out_halted_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/core/lc3_ctrl.sv =====
// Controller: sequences each beat through write, read or set-PC, or through fetch, execute, memory and string steps.
`timescale 1ns / 1ps
module lc3_ctrl import lc3_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_READ, S_SETPC, S_FETCH, S_DECODE, S_EXEC, S_IND,
    S_LOADWB, S_STI, S_SRD, S_SCHK, S_SHI, S_DONE
  } state_t;

  state_t state_r;
  logic   packed_str;

  assign packed_str = stat.vector == TV_PUTSP;
  assign busy       = state_r != S_IDLE;

  always_comb begin
    case (state_r)
      S_IDLE:   cmd.op = start ? OP_LOAD : OP_NONE;
      S_WRITE:  cmd.op = OP_WRITE;
      S_READ:   cmd.op = OP_READ;
      S_SETPC:  cmd.op = OP_SETPC;
      S_FETCH:  cmd.op = OP_FETCH;
      S_DECODE: cmd.op = OP_DECODE;
      S_EXEC:   cmd.op = OP_EXEC;
      S_IND:    cmd.op = OP_IND;
      S_LOADWB: cmd.op = OP_LOADWB;
      S_STI:    cmd.op = OP_STI;
      S_SRD:    cmd.op = OP_SRD;
      S_SCHK:   cmd.op = OP_SCHK;
      S_SHI:    cmd.op = OP_SHI;
      S_DONE:   cmd.op = OP_DONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            case (in_mode)
              MODE_WRITE: state_r <= S_WRITE;
              MODE_READ:  state_r <= S_READ;
              MODE_SETPC: state_r <= S_SETPC;
              default:    state_r <= stat.halted ? S_DONE : S_FETCH;
            endcase
          end
        end
        S_WRITE, S_READ, S_SETPC: state_r <= S_DONE;
        S_FETCH:  state_r <= S_DECODE;
        S_DECODE: state_r <= S_EXEC;
        S_EXEC: begin
          case (stat.opcode)
            OPC_LD, OPC_LDR: state_r <= S_LOADWB;
            OPC_LDI:         state_r <= S_IND;
            OPC_STI:         state_r <= S_STI;
            OPC_TRAP: begin
              if (stat.vector == TV_PUTS || stat.vector == TV_PUTSP) state_r <= S_SRD;
              else state_r <= S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_IND:    state_r <= S_LOADWB;
        S_LOADWB: state_r <= S_DONE;
        S_STI:    state_r <= S_DONE;
        S_SRD:    state_r <= S_SCHK;
        S_SCHK: begin
          if (stat.word_zero || stat.str_full) state_r <= S_DONE;
          else if (packed_str) state_r <= S_SHI;
          else state_r <= S_SRD;
        end
        S_SHI: begin
          if (stat.hi_zero || stat.str_full) state_r <= S_DONE;
          else state_r <= S_SRD;
        end
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/lc3_instruction_core.sv =====
// Top level of the LC-3 instruction core: controller, datapath and checks.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; busy stays high until
// the final result of that item is on the out_ ports. Every result appears
// for one cycle with out_valid high and cannot be held off. Steps, set by
// the single-port word memory with registered read: write, read and set-PC
// do one step and report; an instruction runs fetch, decode, execute, report,
// loads and STI add a memory step and LDI two; PUTS reads and checks each
// word, PUTSP also its high byte. Executing while halted just reports.
module lc3_instruction_core import lc3_pkg::*; #(
  parameter int ADDR_BITS        = 16,
  parameter int MAX_STRING_CHARS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_address,
  input  logic [15:0] in_data,
  input  logic [7:0]  in_char_in,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_char_out,
  output logic [15:0] out_read_data,
  output logic [15:0] out_pc_now,
  output logic [2:0]  out_cond_code,
  output logic        out_halted,
  output logic [2:0]  out_status,
  output logic        out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lc3_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  lc3_dp #(
    .ADDR_BITS        (ADDR_BITS),
    .MAX_STRING_CHARS (MAX_STRING_CHARS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_mode       (in_mode),
    .in_address    (in_address),
    .in_data       (in_data),
    .in_char_in    (in_char_in),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_char_out  (out_char_out),
    .out_read_data (out_read_data),
    .out_pc_now    (out_pc_now),
    .out_cond_code (out_cond_code),
    .out_halted    (out_halted),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result beat follows a final beat directly");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final beat while core is idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CHAR |-> out_last)
    else $error("non-character beat not marked final");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("status on a non-final beat");

endmodule
